// ----- rtl/planar_odometry_integrator_unit_defines.svh -----
// Assertion macros for the odometry integrator RTL.
// Included by poi_back, which carries concurrent checks; no other dependencies.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_DEFINES_SVH

// Implication check clocked on clock, muted during reset.
`define POI_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication check clocked on clock, muted during reset.
`define POI_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/poi_pkg.sv -----
// Shared types and constants for the odometry integrator.
// No dependencies.
package poi_pkg;

   localparam int VelW     = 16;
   localparam int ElW      = 20;
   localparam int QuatW    = 18;
   localparam int CordW    = 34;
   localparam int CordFrac = 30;
   localparam int CordSteps = 31;
   localparam logic signed [CordW-1:0] CordGain = 34'sd652032874;

   typedef struct packed {
      logic signed [VelW-1:0] vel_x;
      logic signed [VelW-1:0] vel_y;
      logic signed [VelW-1:0] turn_rate;
      logic        [ElW-1:0]  elapsed;
      logic                   frame_ok;
   } req_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIG1, ST_MUL1, ST_MUL2, ST_ACC, ST_TRIG2, ST_EMIT
   } back_state_type;

   typedef enum logic [1:0] {CR_IDLE, CR_RUN, CR_DONE} cordic_state_type;

   function automatic logic signed [CordW-1:0] atan_val(input logic [4:0] i);
      logic signed [CordW-1:0] r;
      unique case (i)
         5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;        5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;        5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;         5'd29: r = 34'sd1;
         5'd30: r = 34'sd1;         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/poi_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on poi_pkg.
module poi_cordic #(
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            angle,
   output logic                   done,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_out,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_out
);
   import poi_pkg::*;

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int Sh = CordFrac - TRIG_FRAC_BITS;

   cordic_state_type state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic signed [CordW-1:0] x_ff, x_in, y_ff, y_in, t_ff, t_in;
   logic neg_ff, neg_in;

   logic signed [CordW-1:0] ts;
   logic signed [CordW-1:0] xs, ys;

   function automatic logic signed [TW-1:0] to_trig(input logic signed [CordW-1:0] v);
      logic signed [CordW-1:0] r;
      r = (v + (CordW'(1) <<< (Sh - 1))) >>> Sh;
      if (r > (CordW'(1) <<< TRIG_FRAC_BITS)) r = CordW'(1) <<< TRIG_FRAC_BITS;
      if (r < -(CordW'(1) <<< TRIG_FRAC_BITS)) r = -(CordW'(1) <<< TRIG_FRAC_BITS);
      return r[TW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CR_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      x_ff <= x_in; y_ff <= y_in; t_ff <= t_in; neg_ff <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in = x_ff; y_in = y_ff; t_in = t_ff; neg_in = neg_ff;
      ts = CordW'(signed'(angle));
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      unique case (state_ff)
         CR_IDLE, CR_DONE: begin
            if (start) begin
               // fold angles beyond a quarter turn by a half turn
               neg_in = 1'b0;
               if (ts > (CordW'(1) <<< 30)) begin
                  ts = ts - (CordW'(1) <<< 31); neg_in = 1'b1;
               end else if (ts < -(CordW'(1) <<< 30)) begin
                  ts = ts + (CordW'(1) <<< 31); neg_in = 1'b1;
               end
               t_in = ts; x_in = CordGain; y_in = '0;
               step_in = '0; state_in = CR_RUN;
            end
         end
         CR_RUN: begin
            if (!t_ff[CordW-1]) begin
               x_in = x_ff - ys; y_in = y_ff + xs; t_in = t_ff - atan_val(step_ff);
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; t_in = t_ff + atan_val(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CordSteps - 1)) state_in = CR_DONE;
         end
         default: state_in = CR_IDLE;
      endcase
   end

   assign done    = (state_ff == CR_DONE);
   assign cos_out = to_trig(neg_ff ? -x_ff : x_ff);
   assign sin_out = to_trig(neg_ff ? -y_ff : y_ff);
endmodule

// ----- rtl/poi_front.sv -----
// Front end: accepts velocity reports into a two-entry queue.
// Depends on poi_pkg.
module poi_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  poi_pkg::req_item_type  req_item,
   output logic                   q_valid,
   input  logic                   q_pop,
   output poi_pkg::req_item_type  q_item
);
   import poi_pkg::*;

   req_item_type mem_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_item;
   end

   always_comb begin
      wr_in = wr_ff ^ push;
      rd_in = rd_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end
endmodule

// ----- rtl/poi_back.sv -----
// Back end: pose update sequencer with shared CORDIC and output register.
// Depends on poi_pkg, poi_cordic and the defines header.
module poi_back #(
   parameter int POS_BITS       = 56,
   parameter int ANGLE_BITS     = 32,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  poi_pkg::req_item_type   q_item,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [POS_BITS-1:0] pose_x,
   output logic signed [POS_BITS-1:0] pose_y,
   output logic [ANGLE_BITS-1:0]   heading,
   output logic [17:0]             quat_z,
   output logic [17:0]             quat_w,
   output logic                    updated
);
   import poi_pkg::*;
`include "planar_odometry_integrator_unit_defines.svh"

   localparam int TW = TRIG_FRAC_BITS + 2;
   localparam int PW = VelW + TW + 1;        // vel * trig product
   localparam int SW = PW + 1;               // sum of two products
   localparam int MW = SW + ElW + 1;         // times elapsed
   localparam int WW = (MW > POS_BITS ? MW : POS_BITS) + 2;

   back_state_type state_ff, state_in;
   logic signed [POS_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [ANGLE_BITS-1:0] yaw_ff, yaw_in;
   req_item_type item_ff, item_in;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in, p3_in;
   logic signed [MW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic out_v_ff, out_v_in;
   logic signed [POS_BITS-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [ANGLE_BITS-1:0] oh_ff, oh_in;
   logic [17:0] oz_ff, oz_in, ow_ff, ow_in;
   logic ou_ff, ou_in;

   logic cr_start, cr_done;
   logic [31:0] cr_angle, yaw32;
   logic signed [TW-1:0] cr_cos, cr_sin;
   logic signed [MW-1:0] dth_full;
   logic signed [31:0] dth;
   logic signed [WW-1:0] dx, dy, sx, sy;

   poi_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cordic (
      .clock(clock), .reset(reset), .start(cr_start), .angle(cr_angle),
      .done(cr_done), .cos_out(cr_cos), .sin_out(cr_sin)
   );

   function automatic logic signed [POS_BITS-1:0] sat(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi, lo;
      hi = WW'({1'b0, {(POS_BITS-1){1'b1}}});
      lo = -hi - WW'(1);
      if (v > hi) return hi[POS_BITS-1:0];
      if (v < lo) return lo[POS_BITS-1:0];
      return v[POS_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         px_ff <= '0; py_ff <= '0; yaw_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         px_ff <= px_in; py_ff <= py_in; yaw_ff <= yaw_in;
         out_v_ff <= out_v_in;
      end
      item_ff <= item_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      mx_ff <= mx_in; my_ff <= my_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oh_ff <= oh_in;
      oz_ff <= oz_in; ow_ff <= ow_in; ou_ff <= ou_in;
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff; py_in = py_ff; yaw_in = yaw_ff;
      item_in = item_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      mx_in = mx_ff; my_in = my_ff;
      out_v_in = out_v_ff && !rsp_tready;
      ox_in = ox_ff; oy_in = oy_ff; oh_in = oh_ff;
      oz_in = oz_ff; ow_in = ow_ff; ou_in = ou_ff;
      q_pop = 1'b0;
      cr_start = 1'b0;
      yaw32 = 32'(yaw_ff) << (32 - ANGLE_BITS);
      cr_angle = yaw32;
      dth_full = MW'(item_ff.turn_rate) * MW'(signed'({1'b0, item_ff.elapsed}));
      dth = 32'(dth_full >>> (32 - ANGLE_BITS));
      dx = (WW'(mx_ff) + (WW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
      dy = (WW'(my_ff) + (WW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
      sx = WW'(px_ff) + dx;
      sy = WW'(py_ff) + dy;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               item_in = q_item;
               cr_start = 1'b1;
               state_in = q_item.frame_ok ? ST_TRIG1 : ST_TRIG2;
               if (!q_item.frame_ok) cr_angle = yaw32 >> 1;
            end
         end
         ST_TRIG1: if (cr_done) begin
            p0_in = PW'(item_ff.vel_x) * PW'(cr_cos);
            p1_in = PW'(item_ff.vel_y) * PW'(cr_sin);
            p2_in = PW'(item_ff.vel_x) * PW'(cr_sin);
            p3_in = PW'(item_ff.vel_y) * PW'(cr_cos);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mx_in = MW'(SW'(p0_ff) - SW'(p1_ff));
            my_in = MW'(SW'(p2_ff) + SW'(p3_ff));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mx_in = mx_ff * MW'(signed'({1'b0, item_ff.elapsed}));
            my_in = my_ff * MW'(signed'({1'b0, item_ff.elapsed}));
            state_in = ST_ACC;
         end
         ST_ACC: begin
            px_in = sat(sx);
            py_in = sat(sy);
            yaw_in = yaw_ff + ANGLE_BITS'(dth);
            state_in = ST_TRIG2;
            cr_start = 1'b1;
            cr_angle = (32'(yaw_in) << (32 - ANGLE_BITS)) >> 1;
         end
         ST_TRIG2: if (cr_done && !out_v_ff) begin
            // hold the result until the output register frees up
            out_v_in = 1'b1;
            ox_in = px_ff; oy_in = py_ff; oh_in = yaw_ff;
            oz_in = 18'(cr_sin); ow_in = 18'(cr_cos);
            ou_in = item_ff.frame_ok;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = out_v_ff;
   assign pose_x = ox_ff; assign pose_y = oy_ff; assign heading = oh_ff;
   assign quat_z = oz_ff; assign quat_w = ow_ff; assign updated = ou_ff;

   `POI_ASSERT_NXT(a_pop_leaves_idle, clock, reset, q_pop, state_ff != ST_IDLE, "pop stayed idle")
   `POI_ASSERT_IMP(a_pop_has_item, clock, reset, q_pop, q_valid, "pop with empty queue")
   `POI_ASSERT_NXT(a_reject_keeps_pose, clock, reset, q_pop && !q_item.frame_ok, $stable(px_ff) && $stable(yaw_ff), "rejected frame moved pose")
endmodule

// ----- rtl/planar_odometry_integrator_unit.sv -----
// Top level of the planar odometry integrator.
// Depends on poi_pkg, poi_front and poi_back.
//
// Dead-reckoning integrator for a holonomic base. Each request beat is a
// velocity report; each response beat carries the pose, heading, yaw
// quaternion and an updated flag. The back end works on one report at a
// time on a single shared iterative CORDIC. A valid frame holds the back
// end for the pop, one CORDIC run on the old heading, multiply, sum,
// scale and accumulate steps, then a second CORDIC run on the new half
// heading. A rejected frame runs only the half-heading CORDIC. A
// two-entry queue accepts requests while the back end works, and a
// response register lets the next report start while a result waits for
// rsp_tready.
module planar_odometry_integrator_unit #(
   parameter int POS_BITS       = 56,
   parameter int ANGLE_BITS     = 32,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: vel_x[15:0], vel_y[31:16], turn_rate[47:32], elapsed[67:48], pad
   input  logic [71:0]  req_tdata,
   // tuser: frame_ok
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: pose_x, pose_y, heading, quat_z, quat_w, zero pad to bytes
   output logic [((2*POS_BITS+ANGLE_BITS+36+7)/8)*8-1:0] rsp_tdata,
   // tuser: updated
   output logic         rsp_tuser
);
   import poi_pkg::*;

   localparam int OW = ((2*POS_BITS+ANGLE_BITS+36+7)/8)*8;
   localparam int PadW = OW - (2*POS_BITS+ANGLE_BITS+36);

   req_item_type in_item, q_item;
   logic q_valid, q_pop;
   logic signed [POS_BITS-1:0] px, py;
   logic [ANGLE_BITS-1:0] hd;
   logic [17:0] qz, qw;

   // unpack request beat
   assign in_item.vel_x     = req_tdata[15:0];
   assign in_item.vel_y     = req_tdata[31:16];
   assign in_item.turn_rate = req_tdata[47:32];
   assign in_item.elapsed   = req_tdata[67:48];
   assign in_item.frame_ok  = req_tuser;

   poi_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_item(in_item),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   poi_back #(
      .POS_BITS(POS_BITS), .ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .pose_x(px), .pose_y(py), .heading(hd),
      .quat_z(qz), .quat_w(qw), .updated(rsp_tuser)
   );

   // pack response beat, first field lowest
   assign rsp_tdata = {{PadW{1'b0}}, qw, qz, hd, py, px};
endmodule

// ----- sim/planar_odometry_integrator_unit_checker.sv -----
// Pose checker for the planar odometry integrator: watches both streams,
// predicts each response beat and compares it field by field.
// Depends on poi_pkg for the request beat layout.
`timescale 1ns / 100ps

module planar_odometry_integrator_unit_checker #(
   parameter int RspW = 184
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tready,
   input  logic [71:0]     req_tdata,
   input  logic            req_tuser,
   input  logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  logic [RspW-1:0] rsp_tdata,
   input  logic            rsp_tuser,
   output int              pose_errors,
   output int              poses_pending
);
   import poi_pkg::*;

   localparam longint PosHi = (longint'(1) <<< 55) - 1;
   localparam longint PosLo = -PosHi - 1;
   localparam longint Gain  = 652032874;
   localparam longint TurnTbl [0:30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1};

   typedef struct {
      logic [RspW-1:0] data;
      logic            upd;
   } pose_beat_type;

   pose_beat_type  pose_queue[$];
   longint         pos_x, pos_y;
   logic [31:0]    yaw;

   // round a 30-fraction CORDIC value to Q1.16 and clamp to +-1
   function automatic longint to_q16(input longint v);
      longint r;
      r = (v + (longint'(1) <<< 13)) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r;
   endfunction

   function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                   output longint s);
      longint t, x, y, nx;
      bit flip;
      t = longint'(ang);
      x = Gain;
      y = 0;
      flip = 0;
      if (t >= (longint'(1) <<< 31)) t -= longint'(1) <<< 32;
      // fold anything past a quarter turn by a half turn
      if (t > (longint'(1) <<< 30)) begin
         t -= longint'(1) <<< 31;
         flip = 1;
      end else if (t < -(longint'(1) <<< 30)) begin
         t += longint'(1) <<< 31;
         flip = 1;
      end
      for (int i = 0; i < 31; i++) begin
         if (t >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            t -= TurnTbl[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            t += TurnTbl[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = to_q16(x);
      s = to_q16(y);
   endfunction

   function automatic longint clamp_pos(input longint p, input longint d);
      longint r;
      r = p + d;
      if (r > PosHi) r = PosHi;
      if (r < PosLo) r = PosLo;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t pose mismatch on %s: expected %h, actual %h", $time, name,
                  want, got);
         pose_errors++;
      end
   endfunction

   always @(posedge clock) begin
      req_item_type  rq;
      pose_beat_type pb;
      longint vx, vy, tr, el, c, s, dx, dy, qz, qw, dth;
      if (reset) begin
         pos_x = 0;
         pos_y = 0;
         yaw   = '0;
         pose_queue.delete();
         pose_errors   = 0;
         poses_pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.vel_x     = req_tdata[15:0];
            rq.vel_y     = req_tdata[31:16];
            rq.turn_rate = req_tdata[47:32];
            rq.elapsed   = req_tdata[67:48];
            rq.frame_ok  = req_tuser;
            vx = longint'(rq.vel_x);
            vy = longint'(rq.vel_y);
            tr = longint'(rq.turn_rate);
            el = longint'({44'b0, rq.elapsed});
            if (rq.frame_ok) begin
               // rotate by the heading held before this step
               sin_cos(yaw, c, s);
               dx = ((vx * c - vy * s) * el + 32768) >>> 16;
               dy = ((vx * s + vy * c) * el + 32768) >>> 16;
               pos_x = clamp_pos(pos_x, dx);
               pos_y = clamp_pos(pos_y, dy);
               dth = tr * el;
               yaw = yaw + dth[31:0];
            end
            sin_cos(yaw >> 1, qw, qz);
            pb.data = '0;
            pb.data[55:0]    = pos_x[55:0];
            pb.data[111:56]  = pos_y[55:0];
            pb.data[143:112] = yaw;
            pb.data[161:144] = qz[17:0];
            pb.data[179:162] = qw[17:0];
            pb.upd = rq.frame_ok;
            pose_queue.insert(pose_queue.size(), pb);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pose_queue.size() == 0) begin
               $display("%0t pose beat with none expected: actual %h", $time,
                        rsp_tdata);
               pose_errors++;
            end else begin
               pb = pose_queue.pop_front();
               check_field("pose_x", pb.data[55:0], rsp_tdata[55:0]);
               check_field("pose_y", pb.data[111:56], rsp_tdata[111:56]);
               check_field("heading", pb.data[143:112], rsp_tdata[143:112]);
               check_field("quat_z", pb.data[161:144], rsp_tdata[161:144]);
               check_field("quat_w", pb.data[179:162], rsp_tdata[179:162]);
               check_field("pad", pb.data[RspW-1:180], rsp_tdata[RspW-1:180]);
               check_field("updated", pb.upd, rsp_tuser);
            end
         end
         poses_pending <= pose_queue.size();
      end
   end

endmodule

// ----- sim/planar_odometry_integrator_unit_tb.sv -----
// Testbench top for the planar odometry integrator: drives velocity reports
// with random gaps and back-pressure, and reports the verdict.
// Depends on poi_pkg, the block and planar_odometry_integrator_unit_checker.
`timescale 1ns / 100ps

module planar_odometry_integrator_unit_tb;
   import poi_pkg::*;

   localparam int RspW = 184;
   localparam int RandomReports = 1730;

   logic            clock;
   logic            reset;
   logic            req_tvalid;
   logic            req_tready;
   logic [71:0]     req_tdata;   // vel_x, vel_y, turn_rate, elapsed, zero pad
   logic            req_tuser;   // frame_ok
   logic            rsp_tvalid;
   logic            rsp_tready;
   logic [RspW-1:0] rsp_tdata;   // pose_x, pose_y, heading, quat_z, quat_w, pad
   logic            rsp_tuser;   // updated
   int              pose_errors;
   int              poses_pending;
   int              reports_sent;
   int              rejects_sent;
   bit              no_gaps;     // stretches with both sides at full rate

   planar_odometry_integrator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   planar_odometry_integrator_unit_checker #(.RspW(RspW)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .pose_errors   (pose_errors),
      .poses_pending (poses_pending)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the run hangs.
   initial begin
      #50ms;
      $display("[planar_odometry_integrator_unit] ERROR");
      $finish;
   end

   // Drive one report beat: hold valid low for a random gap, then present
   // the beat and hold it until the block takes it.
   task automatic send_report(input logic signed [15:0] vx, input logic signed [15:0] vy,
                              input logic signed [15:0] tr, input logic [19:0] el,
                              input logic ok);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, el, tr, vy, vx};
      req_tuser  <= ok;
      do @(posedge clock); while (!req_tready);
      reports_sent++;
      if (!ok) rejects_sent++;
   endtask

   // Response side: stall a random number of cycles before each beat.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      logic [19:0] el;
      logic        ok;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      no_gaps      = 0;
      reports_sent = 0;
      rejects_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero step, rejected frames at the extremes, then full-scale
      // steps along x and y in both directions, and spin both ways.
      send_report(16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b1);
      send_report(16'sh7fff, 16'sh7fff, 16'sh7fff, 20'hfffff, 1'b0);
      send_report(-16'sh8000, -16'sh8000, -16'sh8000, 20'hfffff, 1'b0);
      repeat (5) send_report(16'sh7fff, 16'sd0, 16'sd0, 20'hfffff, 1'b1);
      send_report(16'sd0, 16'sh7fff, 16'sd0, 20'hfffff, 1'b1);
      send_report(-16'sh8000, 16'sd0, 16'sd0, 20'hfffff, 1'b1);
      send_report(16'sd1, -16'sd1, 16'sd1, 20'd1, 1'b1);
      send_report(16'sd0, 16'sd0, 16'sh7fff, 20'hfffff, 1'b1);
      send_report(16'sd0, 16'sd0, -16'sh8000, 20'hfffff, 1'b1);
      send_report(16'sd0, 16'sd0, 16'sd4096, 20'h80000, 1'b1);
      repeat (4) send_report(16'sh7fff, -16'sh8000, 16'sd0, 20'hfffff, 1'b1);
      send_report(-16'sh8000, -16'sh8000, 16'sd2048, 20'hfffff, 1'b1);
      send_report(16'sd0, 16'sd0, 16'sd0, 20'hfffff, 1'b0);

      for (int n = 0; n < RandomReports; n++) begin
         // alternate stretches with and without idling on both sides
         if (n % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         // hold off once until the block has drained completely
         if (n == RandomReports / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (poses_pending != 0) @(posedge clock);
         end
         el = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4095));
         ok = ($urandom_range(0, 6) != 0);
         send_report(16'($urandom), 16'($urandom), 16'($urandom), el, ok);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (poses_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("Covered %0d velocity reports, %0d of them rejected frames,",
               reports_sent, rejects_sent);
      $display("with full-scale steps, heading wrap and random stalls on both sides.");
      if (pose_errors == 0 && poses_pending == 0) begin
         $display("[planar_odometry_integrator_unit] OK");
      end else begin
         $display("[planar_odometry_integrator_unit] ERROR");
      end
      $finish;
   end

endmodule
